// ===== sv/ess_pkg.sv =====
// ess_pkg: shared types, codes and fixed-point constants for the engine
// sound synthesizer. No dependencies; used by ess_div and engine_sound_synth_top.
`timescale 1ns / 1ps

package ess_pkg;

    // Phase accumulator and sine index geometry
    localparam int PHASE_BITS       = 24;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int TBL_BITS         = $clog2(SINE_TABLE_DEPTH);

    // Shared multiplier operand and product widths
    localparam int MUL_A_W = 42;
    localparam int MUL_B_W = 22;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Phase increment divider: (smooth_rpm << PHASE_BITS) + den/2 over den
    localparam int DIV_NUM_W = 24 + PHASE_BITS + 1;
    localparam int DIV_DEN_W = 35;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_RATE   = 2'd0;
    localparam logic [1:0] CFG_NOISE_GAIN    = 2'd1;
    localparam logic [1:0] CFG_BACKFIRE_GAIN = 2'd2;

    // Action codes
    localparam logic [1:0] ACT_BEGIN   = 2'd0;
    localparam logic [1:0] ACT_RENDER  = 2'd1;
    localparam logic [1:0] ACT_TRIGGER = 2'd2;
    localparam logic [1:0] ACT_UNUSED  = 2'd3;

    // Quality tiers
    localparam logic [1:0] QUAL_FAR  = 2'd0;
    localparam logic [1:0] QUAL_NEAR = 2'd1;

    // Reset values
    localparam logic [17:0] SAMPLE_RATE_DEFAULT = 18'd44100;
    localparam logic [15:0] GAIN_DEFAULT        = 16'd4096;

    // Q0.16 constants
    localparam logic [21:0] K_SMOOTH    = 22'd3277;
    localparam logic [15:0] K_AMP_BASE  = 16'd1966;
    localparam logic [21:0] K_AMP_SLOPE = 22'd5243;
    localparam logic [21:0] K_FAR       = 22'd36045;
    localparam logic [21:0] K_NEAR      = 22'd55706;
    localparam logic [21:0] K_HARM      = 22'd22938;
    localparam logic [21:0] K_DECAY     = 22'd63570;
    localparam logic [21:0] K_NOISE     = 22'd1311;
    localparam logic [21:0] K_POP       = 22'd6554;
    localparam logic [16:0] ENV_FLOOR   = 17'd65;
    localparam logic [16:0] ENV_ONE     = 17'd65536;
    localparam logic [15:0] AMP_MAX     = 16'd7209;

    // Sine polynomial coefficients (Q14)
    localparam logic [14:0] SIN_C1     = 15'd25732;
    localparam logic [14:0] SIN_C3     = 15'd10538;
    localparam logic [21:0] SIN_C5     = 22'd1190;
    localparam logic [14:0] QUARTER    = 15'd16384;

    // Noise generator
    localparam logic [21:0] LCG_MUL = 22'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    typedef struct packed {
        logic [1:0]         action;
        logic [13:0]        rpm;
        logic [15:0]        throttle;
        logic [1:0]         quality;
        logic signed [15:0] mix_left;
        logic signed [15:0] mix_right;
    } ess_in_t;

    typedef struct packed {
        logic signed [15:0] out_left;
        logic signed [15:0] out_right;
    } ess_out_t;

endpackage

// ===== sv/ess_div.sv =====
// ess_div: restoring divider, one quotient bit per cycle, for the phase
// increment. Depends on ess_pkg for widths.
`timescale 1ns / 1ps

module ess_div import ess_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 busy,
    output logic [DIV_NUM_W-1:0] quot
);

    logic [DIV_NUM_W-1:0] quo_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DIV_CNT_W'(DIV_NUM_W);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[DIV_NUM_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign quot = quo_reg;

    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && den_reg != '0 && !$past(start) |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

    a_busy_count: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with empty count");

endmodule

// ===== sv/engine_sound_synth_top.sv =====
// engine_sound_synth_top: engine tone synthesizer around one shared multiplier
// and a small sequencer. Depends on ess_pkg and ess_div.
`timescale 1ns / 1ps
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------
//  s_       | in        | s_valid / s_ready | ess_in_t  s_data
//  m_       | out       | m_valid / m_ready | ess_out_t m_data
//  cfg_     | in        | cfg_wr_en         | cfg_addr, cfg_wdata
//
//  A render transaction takes extra steps when the backfire pop is active; most
//  steps are one pass through the shared 42x22 multiplier. A begin-block
//  transaction waits on the 49-step phase increment divider. Trigger and
//  unused actions complete in the accepting cycle. s_ready is high only when
//  the sequencer is idle; a finished result waits in the output register and
//  holds the sequencer only if the previous result is still untaken.
//  Reset is synchronous, active low, and restores all but the data registers.

module engine_sound_synth_top import ess_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  ess_in_t     s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output ess_out_t    m_data,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [17:0] cfg_wdata
);

    typedef enum logic [25:0] {
        ST_IDLE    = 26'b1 << 0,
        ST_B_RPM   = 26'b1 << 1,
        ST_B_THR   = 26'b1 << 2,
        ST_B_DIV   = 26'b1 << 3,
        ST_B_AMP   = 26'b1 << 4,
        ST_B_SCL   = 26'b1 << 5,
        ST_B_FIN   = 26'b1 << 6,
        ST_B_WAIT  = 26'b1 << 7,
        ST_R_PHASE = 26'b1 << 8,
        ST_SN_SQ   = 26'b1 << 9,
        ST_SN_A    = 26'b1 << 10,
        ST_SN_B    = 26'b1 << 11,
        ST_SN_C    = 26'b1 << 12,
        ST_SN_D    = 26'b1 << 13,
        ST_H_SUM   = 26'b1 << 14,
        ST_H_ACC   = 26'b1 << 15,
        ST_N_LCG   = 26'b1 << 16,
        ST_N_F0    = 26'b1 << 17,
        ST_N_F1    = 26'b1 << 18,
        ST_N_ADD   = 26'b1 << 19,
        ST_P_LCG   = 26'b1 << 20,
        ST_P_F0    = 26'b1 << 21,
        ST_P_F1    = 26'b1 << 22,
        ST_P_ADD   = 26'b1 << 23,
        ST_P_DEC   = 26'b1 << 24,
        ST_OUT     = 26'b1 << 25
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [17:0] sample_rate_reg;
    logic [15:0] noise_gain_reg;
    logic [15:0] backfire_gain_reg;

    // synth state
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_inc_reg;
    logic [31:0]           noise_state_reg;
    logic [16:0]           env_reg;
    logic [23:0]           srpm_reg;
    logic [23:0]           sthr_reg;
    logic [15:0]           tone_amp_reg;

    // work registers
    ess_in_t                  in_reg;
    logic                     sin_sel_reg;
    logic [14:0]              u2_reg;
    logic signed [15:0]       tone_reg;
    logic signed [19:0]       sum_reg;
    logic signed [PROD_W-1:0] prod_reg;
    ess_out_t                 out_reg;
    logic                     m_valid_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;

    logic signed [PROD_W-1:0] p16, p24, p28, p36;

    assign p16 = (prod_reg + 64'sd32768) >>> 16;
    assign p24 = (prod_reg + 64'sd8388608) >>> 24;
    assign p28 = (prod_reg + 64'sd134217728) >>> 28;
    assign p36 = (prod_reg + 64'sd34359738368) >>> 36;

    // smoothing
    logic signed [24:0] d_rpm, d_thr;
    logic signed [25:0] sm_rpm, sm_thr;
    logic [23:0]        sm_rpm_cl, sm_thr_cl;

    assign d_rpm  = $signed({1'b0, in_reg.rpm, 10'b0}) - $signed({1'b0, srpm_reg});
    assign d_thr  = $signed({1'b0, in_reg.throttle, 8'b0}) - $signed({1'b0, sthr_reg});
    assign sm_rpm = $signed({2'b0, srpm_reg}) + $signed(p16[25:0]);
    assign sm_thr = $signed({2'b0, sthr_reg}) + $signed(p16[25:0]);

    always_comb begin
        if (sm_rpm < 0)
            sm_rpm_cl = '0;
        else if (sm_rpm > 26'sh0FFFFFF)
            sm_rpm_cl = 24'hFFFFFF;
        else
            sm_rpm_cl = sm_rpm[23:0];
        if (sm_thr < 0)
            sm_thr_cl = '0;
        else if (sm_thr > 26'sh0FFFFFF)
            sm_thr_cl = 24'hFFFFFF;
        else
            sm_thr_cl = sm_thr[23:0];
    end

    // divider operands
    logic [17:0]          sr_eff;
    logic [21:0]          sr15;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] div_num;
    logic                 div_busy;
    logic [DIV_NUM_W-1:0] div_quot;

    assign sr_eff  = (sample_rate_reg == '0) ? SAMPLE_RATE_DEFAULT : sample_rate_reg;
    assign sr15    = {sr_eff, 4'b0} - 22'(sr_eff);
    assign div_den = {sr15, 13'b0};
    assign div_num = DIV_NUM_W'({srpm_reg, {PHASE_BITS{1'b0}}})
                   + DIV_NUM_W'(div_den[DIV_DEN_W-1:1]);

    ess_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_B_DIV),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    // sine geometry
    logic [PHASE_BITS-1:0] phase_sel;
    logic [TBL_BITS-1:0]   sin_k;
    logic [15:0]           sin_t;
    logic [14:0]           sin_u;
    logic [15:0]           sin_s;
    logic [15:0]           sin_cap;
    logic [16:0]           sin_dbl;
    logic [15:0]           sin_mag;
    logic signed [15:0]    sin_val;
    logic [14:0]           poly_hi;

    assign phase_sel = sin_sel_reg ? {phase_acc_reg[PHASE_BITS-2:0], 1'b0} : phase_acc_reg;
    assign sin_k     = phase_sel[PHASE_BITS-1 -: TBL_BITS];
    assign sin_t     = {sin_k, {(16 - TBL_BITS){1'b0}}};
    assign sin_u     = sin_t[14] ? (QUARTER - {1'b0, sin_t[13:0]}) : {1'b0, sin_t[13:0]};
    assign poly_hi   = prod_reg[28:14];
    assign sin_s     = prod_reg[29:14];
    assign sin_cap   = (sin_s > 16'd16384) ? 16'd16384 : sin_s;
    assign sin_dbl   = {sin_cap, 1'b0};
    assign sin_mag   = (sin_dbl > 17'd32767) ? 16'd32767 : sin_dbl[15:0];
    assign sin_val   = sin_t[15] ? -$signed(sin_mag) : $signed(sin_mag);

    logic signed [17:0] sum_tn;
    logic signed [15:0] noise_n;
    logic [15:0]        amp_raw;

    assign sum_tn  = 18'(tone_reg) + $signed(p16[17:0]);
    assign noise_n = $signed({~noise_state_reg[23], noise_state_reg[22:8]});
    assign amp_raw = K_AMP_BASE + p24[15:0];

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_B_RPM: begin
                mul_a = MUL_A_W'(d_rpm);
                mul_b = K_SMOOTH;
            end
            ST_B_THR: begin
                mul_a = MUL_A_W'(d_thr);
                mul_b = K_SMOOTH;
            end
            ST_B_AMP: begin
                mul_a = MUL_A_W'(sthr_reg);
                mul_b = K_AMP_SLOPE;
            end
            ST_B_SCL: begin
                mul_a = MUL_A_W'(amp_raw);
                mul_b = (in_reg.quality == QUAL_FAR) ? K_FAR : K_NEAR;
            end
            ST_SN_SQ: begin
                mul_a = MUL_A_W'(sin_u);
                mul_b = MUL_B_W'(sin_u);
            end
            ST_SN_A: begin
                mul_a = MUL_A_W'(poly_hi);
                mul_b = SIN_C5;
            end
            ST_SN_B: begin
                mul_a = MUL_A_W'(u2_reg);
                mul_b = MUL_B_W'(SIN_C3 - poly_hi);
            end
            ST_SN_C: begin
                mul_a = MUL_A_W'(sin_u);
                mul_b = MUL_B_W'(SIN_C1 - poly_hi);
            end
            ST_SN_D: begin
                mul_a = MUL_A_W'(sin_val);
                mul_b = K_HARM;
            end
            ST_H_SUM: begin
                mul_a = MUL_A_W'(sum_tn);
                mul_b = MUL_B_W'(tone_amp_reg);
            end
            ST_H_ACC, ST_N_ADD: begin
                mul_a = MUL_A_W'(noise_state_reg);
                mul_b = LCG_MUL;
            end
            ST_N_LCG: begin
                mul_a = MUL_A_W'(sthr_reg);
                mul_b = MUL_B_W'(noise_gain_reg);
            end
            ST_N_F0: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = K_NOISE;
            end
            ST_N_F1: begin
                mul_a = MUL_A_W'(p36[16:0]);
                mul_b = MUL_B_W'(noise_n);
            end
            ST_P_LCG: begin
                mul_a = MUL_A_W'(env_reg);
                mul_b = MUL_B_W'(backfire_gain_reg);
            end
            ST_P_F0: begin
                mul_a = prod_reg[MUL_A_W-1:0];
                mul_b = K_POP;
            end
            ST_P_F1: begin
                mul_a = MUL_A_W'(p28[17:0]);
                mul_b = MUL_B_W'(noise_n);
            end
            ST_P_ADD: begin
                mul_a = MUL_A_W'(env_reg);
                mul_b = K_DECAY;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // full-width signed product
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // output saturation
    logic signed [20:0] tot_l, tot_r;
    logic signed [15:0] sat_l, sat_r;
    logic               out_free;

    assign tot_l    = 21'(in_reg.mix_left) + 21'(sum_reg);
    assign tot_r    = 21'(in_reg.mix_right) + 21'(sum_reg);
    assign sat_l    = (tot_l > 21'sd32767) ? 16'sh7FFF :
                      (tot_l < -21'sd32768) ? 16'sh8000 : tot_l[15:0];
    assign sat_r    = (tot_r > 21'sd32767) ? 16'sh7FFF :
                      (tot_r < -21'sd32768) ? 16'sh8000 : tot_r[15:0];
    assign out_free = !m_valid_reg || m_ready;

    logic s_fire;
    assign s_fire = s_valid && s_ready;

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.action == ACT_BEGIN)
                        state_next = ST_B_RPM;
                    else if (s_data.action == ACT_RENDER)
                        state_next = ST_R_PHASE;
                end
            end
            ST_B_RPM:   state_next = ST_B_THR;
            ST_B_THR:   state_next = ST_B_DIV;
            ST_B_DIV:   state_next = ST_B_AMP;
            ST_B_AMP:   state_next = ST_B_SCL;
            ST_B_SCL:   state_next = ST_B_FIN;
            ST_B_FIN:   state_next = ST_B_WAIT;
            ST_B_WAIT:  state_next = div_busy ? ST_B_WAIT : ST_IDLE;
            ST_R_PHASE: state_next = ST_SN_SQ;
            ST_SN_SQ:   state_next = ST_SN_A;
            ST_SN_A:    state_next = ST_SN_B;
            ST_SN_B:    state_next = ST_SN_C;
            ST_SN_C:    state_next = ST_SN_D;
            ST_SN_D:    state_next = sin_sel_reg ? ST_H_SUM : ST_SN_SQ;
            ST_H_SUM:   state_next = ST_H_ACC;
            ST_H_ACC:   state_next = ST_N_LCG;
            ST_N_LCG:   state_next = ST_N_F0;
            ST_N_F0:    state_next = ST_N_F1;
            ST_N_F1:    state_next = ST_N_ADD;
            ST_N_ADD:   state_next = (env_reg > ENV_FLOOR) ? ST_P_LCG : ST_OUT;
            ST_P_LCG:   state_next = ST_P_F0;
            ST_P_F0:    state_next = ST_P_F1;
            ST_P_F1:    state_next = ST_P_ADD;
            ST_P_ADD:   state_next = ST_P_DEC;
            ST_P_DEC:   state_next = ST_OUT;
            ST_OUT:     state_next = out_free ? ST_IDLE : ST_OUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            sample_rate_reg   <= SAMPLE_RATE_DEFAULT;
            noise_gain_reg    <= GAIN_DEFAULT;
            backfire_gain_reg <= GAIN_DEFAULT;
            phase_acc_reg     <= '0;
            phase_inc_reg     <= '0;
            noise_state_reg   <= 32'd1;
            env_reg           <= '0;
            srpm_reg          <= '0;
            sthr_reg          <= '0;
            tone_amp_reg      <= '0;
            sin_sel_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                if (cfg_addr == CFG_SAMPLE_RATE)
                    sample_rate_reg <= cfg_wdata;
                else if (cfg_addr == CFG_NOISE_GAIN)
                    noise_gain_reg <= cfg_wdata[15:0];
                else if (cfg_addr == CFG_BACKFIRE_GAIN)
                    backfire_gain_reg <= cfg_wdata[15:0];
            end

            // raise on a new result, drop once the held one is taken
            if (state_reg == ST_OUT && out_free)
                m_valid_reg <= 1'b1;
            else if (m_ready)
                m_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_fire && s_data.action == ACT_TRIGGER)
                        env_reg <= ENV_ONE;
                end
                ST_B_THR: srpm_reg <= sm_rpm_cl;
                ST_B_DIV: sthr_reg <= sm_thr_cl;
                ST_B_SCL: tone_amp_reg <= amp_raw;
                ST_B_FIN: begin
                    if (in_reg.quality == QUAL_FAR || in_reg.quality == QUAL_NEAR)
                        tone_amp_reg <= p16[15:0];
                end
                ST_B_WAIT: begin
                    if (!div_busy)
                        phase_inc_reg <= div_quot[PHASE_BITS-1:0];
                end
                ST_R_PHASE: begin
                    phase_acc_reg <= phase_acc_reg + phase_inc_reg;
                    sin_sel_reg   <= 1'b0;
                end
                ST_SN_D: begin
                    if (!sin_sel_reg)
                        sin_sel_reg <= 1'b1;
                end
                ST_N_LCG, ST_P_LCG: noise_state_reg <= prod_reg[31:0] + LCG_ADD;
                ST_P_DEC: env_reg <= p16[16:0];
                default: begin
                end
            endcase
        end
    end

    // payload and work registers
    always_ff @(posedge aclk) begin
        if (s_fire)
            in_reg <= s_data;
        case (state_reg)
            ST_SN_A:  u2_reg <= poly_hi;
            ST_SN_D: begin
                if (!sin_sel_reg)
                    tone_reg <= sin_val;
            end
            ST_H_ACC: sum_reg <= $signed(p16[19:0]);
            ST_N_ADD, ST_P_ADD: sum_reg <= sum_reg + $signed(p16[19:0]);
            ST_OUT: begin
                if (out_free) begin
                    out_reg.out_left  <= sat_l;
                    out_reg.out_right <= sat_r;
                end
            end
            default: begin
            end
        endcase
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output step");

    a_env_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        env_reg <= ENV_ONE)
        else $error("backfire envelope above one");

    a_amp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        tone_amp_reg <= AMP_MAX)
        else $error("tone amplitude out of range");

    a_idle_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !div_busy)
        else $error("divider still busy while idle");

    a_no_result_on_begin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_B_WAIT |=> !$rose(m_valid_reg))
        else $error("begin-block transaction produced a result");

endmodule
